// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("clocked assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ----- rtl/lcls_pkg.sv -----
// ----------------------------------------------------------------------------
// lcls_pkg
// types, constants and byte-forming functions of the led cube layer scan driver
// ----------------------------------------------------------------------------
package lcls_pkg;

  localparam int CUBE_N   = 5;
  localparam int ROWS     = CUBE_N * CUBE_N;
  localparam int ROW_W    = 3 * CUBE_N;
  localparam int ROW_AW   = $clog2(ROWS);
  localparam int VARIANTS = 3;

  localparam logic [2:0] TOP_ROW   = 3'(CUBE_N - 1);
  localparam logic [2:0] TOP_LAYER = 3'(CUBE_N - 1);

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // emitted colour order
  localparam logic [1:0] COL_RED   = 2'd0;
  localparam logic [1:0] COL_BLUE  = 2'd1;
  localparam logic [1:0] COL_GREEN = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] pos_x;
    logic [2:0] pos_y;
    logic [2:0] pos_z;
    logic [2:0] colour_bits;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  localparam logic [7:0] LAYER_SEL [VARIANTS][CUBE_N][2] = '{
    '{'{8'h01, 8'h09}, '{8'h28, 8'h80}, '{8'h50, 8'h40}, '{8'h84, 8'h24}, '{8'h02, 8'h12}},
    '{'{8'h00, 8'h01}, '{8'h00, 8'h02}, '{8'h00, 8'h20}, '{8'h00, 8'h40}, '{8'h00, 8'h80}},
    '{'{8'h01, 8'h09}, '{8'h02, 8'h02}, '{8'h48, 8'h80}, '{8'hA0, 8'h40}, '{8'h04, 8'h24}}
  };

  // x position feeding bits 1..5, per variant and emitted colour
  localparam logic [2:0] X_MAP [VARIANTS][3][CUBE_N] = '{
    '{'{3'd1, 3'd0, 3'd2, 3'd3, 3'd4}, '{3'd1, 3'd0, 3'd2, 3'd3, 3'd4},
      '{3'd1, 3'd0, 3'd4, 3'd3, 3'd2}},
    '{'{3'd1, 3'd0, 3'd2, 3'd3, 3'd4}, '{3'd1, 3'd0, 3'd4, 3'd3, 3'd2},
      '{3'd1, 3'd0, 3'd2, 3'd3, 3'd4}},
    '{'{3'd3, 3'd4, 3'd2, 3'd1, 3'd0}, '{3'd3, 3'd4, 3'd2, 3'd1, 3'd0},
      '{3'd3, 3'd4, 3'd2, 3'd1, 3'd0}}
  };

  // store bit per emitted colour: red bit0, blue bit2, green bit1
  localparam logic [1:0] COLOUR_BIT [3] = '{2'd0, 2'd2, 2'd1};

  function automatic logic [ROW_AW-1:0] row_addr(logic [2:0] y, logic [2:0] z);
    return ROW_AW'({z, 2'b00}) + ROW_AW'(z) + ROW_AW'(y);
  endfunction

  function automatic logic [7:0] layer_byte(logic [1:0] v, logic [2:0] z, logic second);
    logic [7:0] b;
    b = '0;
    if (v < 2'(VARIANTS) && z <= TOP_LAYER) begin
      b = LAYER_SEL[v][z][second];
    end
    return b;
  endfunction

  function automatic logic [7:0] row_byte(logic [1:0] v, logic [1:0] c,
                                          logic [ROW_W-1:0] row);
    logic [7:0] acc;
    logic [3:0] bit_idx;
    acc = '0;
    if (v < 2'(VARIANTS) && c <= COL_GREEN) begin
      for (int b = 0; b < CUBE_N; b++) begin
        bit_idx = 4'(X_MAP[v][c][b]) * 4'd3 + 4'(COLOUR_BIT[c]);
        acc[b + 1] = row[bit_idx];
      end
    end
    return acc;
  endfunction

endpackage

// ----- rtl/led_cube_layer_scan_driver_top.sv -----
// ----------------------------------------------------------------------------
// led_cube_layer_scan_driver_top
// scan driver for a 5x5x5 rgb led cube: voxel store and 17-byte layer frames
// ----------------------------------------------------------------------------
//   channel   direction  payload          handshake
//   item      in         lcls_pkg::item_t   item_valid / item_ready
//   res       out        lcls_pkg::result_t res_valid / res_ready
//   cfg       in         board_variant    cfg_we (no wait)
//
// a tick first steps the layer, then sends one byte a cycle while res is not
// stalled, paced by the single read port of the row ram.
// a voxel write reads the row, then merges and writes it back; clear and
// ignored items leave the sequencer in idle. every stall on res holds the sequencer in place.
// reset clears the store at once through per-row valid bits, no sweep.
// ----------------------------------------------------------------------------
module led_cube_layer_scan_driver_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  lcls_pkg::item_t   item,
  output logic              res_valid,
  input  logic              res_ready,
  output lcls_pkg::result_t res,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WMERGE = 5'b00010,
    S_LSEL0  = 5'b00100,
    S_LSEL1  = 5'b01000,
    S_ROWS   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [1:0]                    board_variant;
  logic [2:0]                    layer, layer_next;
  logic [1:0]                    colour, colour_next;
  logic [2:0]                    row_y, row_y_next;
  logic [2:0]                    wr_x, wr_x_next;
  logic [2:0]                    wr_colour, wr_colour_next;
  logic [lcls_pkg::ROW_AW-1:0]   wr_addr, wr_addr_next;
  logic [lcls_pkg::ROWS-1:0]     row_valid;
  logic                          rd_valid;

  logic                          ram_we;
  logic                          ram_re;
  logic [lcls_pkg::ROW_AW-1:0]   ram_raddr;
  logic [lcls_pkg::ROW_W-1:0]    ram_wdata;
  logic [lcls_pkg::ROW_W-1:0]    ram_rdata;
  logic [lcls_pkg::ROW_W-1:0]    row_data;
  logic [3:0]                    wr_off;

  logic                          clear_all;
  logic                          out_free;
  logic                          load;
  lcls_pkg::result_t             load_beat;
  logic                          in_range;

  lcls_ram #(
    .WIDTH(lcls_pkg::ROW_W),
    .DEPTH(lcls_pkg::ROWS)
  ) u_rows (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // a row never written since reset or clear reads as all off
  assign row_data   = rd_valid ? ram_rdata : '0;
  assign wr_off     = 4'(wr_x) * 4'd3;
  assign out_free   = !res_valid || res_ready;
  assign item_ready = (state == S_IDLE);
  assign in_range   = (item.pos_x <= lcls_pkg::TOP_ROW) && (item.pos_y <= lcls_pkg::TOP_ROW)
                   && (item.pos_z <= lcls_pkg::TOP_LAYER);

  always_comb begin
    ram_wdata = row_data;
    ram_wdata[wr_off +: 3] = wr_colour;
  end

  always_comb begin
    state_next     = state;
    layer_next     = layer;
    colour_next    = colour;
    row_y_next     = row_y;
    wr_x_next      = wr_x;
    wr_colour_next = wr_colour;
    wr_addr_next   = wr_addr;
    clear_all      = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = lcls_pkg::row_addr(item.pos_y, item.pos_z);
    load           = 1'b0;
    load_beat      = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          unique case (item.kind)
            lcls_pkg::KIND_WRITE: begin
              if (in_range) begin
                ram_re         = 1'b1;
                wr_addr_next   = lcls_pkg::row_addr(item.pos_y, item.pos_z);
                wr_x_next      = item.pos_x;
                wr_colour_next = item.colour_bits;
                state_next     = S_WMERGE;
              end
            end
            lcls_pkg::KIND_CLEAR: begin
              clear_all = 1'b1;
            end
            lcls_pkg::KIND_TICK: begin
              layer_next = (layer >= lcls_pkg::TOP_LAYER) ? 3'd0 : layer + 3'd1;
              state_next = S_LSEL0;
            end
            default: ;
          endcase
        end
      end
      S_WMERGE: begin
        ram_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_LSEL0: begin
        if (out_free) begin
          load               = 1'b1;
          load_beat.out_byte = lcls_pkg::layer_byte(board_variant, layer, 1'b0);
          state_next         = S_LSEL1;
        end
      end
      S_LSEL1: begin
        if (out_free) begin
          load               = 1'b1;
          load_beat.out_byte = lcls_pkg::layer_byte(board_variant, layer, 1'b1);
          ram_re             = 1'b1;
          ram_raddr          = lcls_pkg::row_addr(lcls_pkg::TOP_ROW, layer);
          colour_next        = lcls_pkg::COL_RED;
          row_y_next         = lcls_pkg::TOP_ROW;
          state_next         = S_ROWS;
        end
      end
      S_ROWS: begin
        if (out_free) begin
          load               = 1'b1;
          load_beat.out_byte = lcls_pkg::row_byte(board_variant, colour, row_data);
          if (row_y == 3'd0) begin
            if (colour == lcls_pkg::COL_GREEN) begin
              load_beat.last = 1'b1;
              state_next     = S_IDLE;
            end else begin
              colour_next = colour + 2'd1;
              row_y_next  = lcls_pkg::TOP_ROW;
              ram_re      = 1'b1;
              ram_raddr   = lcls_pkg::row_addr(lcls_pkg::TOP_ROW, layer);
            end
          end else begin
            // fetch the next row while this beat goes out
            row_y_next = row_y - 3'd1;
            ram_re     = 1'b1;
            ram_raddr  = lcls_pkg::row_addr(row_y - 3'd1, layer);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      layer         <= '0;
      board_variant <= '0;
      row_valid     <= '0;
      rd_valid      <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      layer <= layer_next;
      if (cfg_we) begin
        board_variant <= cfg_wdata;
      end
      if (clear_all) begin
        row_valid <= '0;
      end else if (ram_we) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid <= row_valid[ram_raddr];
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    colour    <= colour_next;
    row_y     <= row_y_next;
    wr_x      <= wr_x_next;
    wr_colour <= wr_colour_next;
    wr_addr   <= wr_addr_next;
    if (load) begin
      res <= load_beat;
    end
  end

endmodule

// ----- rtl/lcls_ram.sv -----
// ----------------------------------------------------------------------------
// lcls_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lcls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lcls_checker.sv -----
// ----------------------------------------------------------------------------
// lcls_checker
// port-level assertions for the led cube layer scan driver
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcls_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input lcls_pkg::item_t   item,
  input logic              res_valid,
  input logic              res_ready,
  input lcls_pkg::result_t res
);

  // a stalled beat holds
  `ASSERT_CLK(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res))

  // no new item while a frame is only partly out
  `ASSERT_NEVER(a_busy_mid_frame, clk, rst, res_valid && !res.last && item_ready)

  // a tick keeps the block busy at least through the next cycle
  `ASSERT_CLK(a_tick_busy, clk, rst,
    item_valid && item_ready && item.kind == lcls_pkg::KIND_TICK |=> !item_ready)

  // a clear leaves the block ready again in the next cycle
  `ASSERT_CLK(a_clear_quick, clk, rst,
    item_valid && item_ready && item.kind == lcls_pkg::KIND_CLEAR |=> item_ready)

endmodule

bind led_cube_layer_scan_driver_top lcls_checker u_lcls_checker (.*);

// ----- test/lcls_scan_checker.sv -----
// ----------------------------------------------------------------------------
// lcls_scan_checker
// watches the item, result and config channels of the led cube scan driver,
// keeps its own voxel store and layer count, and checks every result beat
// against the frame bytes it predicts
// ----------------------------------------------------------------------------
module lcls_scan_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  lcls_pkg::item_t   item,
  input  logic              res_valid,
  input  logic              res_ready,
  input  lcls_pkg::result_t res,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  output int                errors,
  output int                pending
);

  localparam int BOARDS      = 3;
  localparam int SIDE        = 5;
  localparam int FRAME_BYTES = 17;

  // layer-select pair per board and layer
  localparam logic [7:0] SELECT_BYTES [BOARDS][SIDE][2] = '{
    '{'{8'h01, 8'h09}, '{8'h28, 8'h80}, '{8'h50, 8'h40}, '{8'h84, 8'h24}, '{8'h02, 8'h12}},
    '{'{8'h00, 8'h01}, '{8'h00, 8'h02}, '{8'h00, 8'h20}, '{8'h00, 8'h40}, '{8'h00, 8'h80}},
    '{'{8'h01, 8'h09}, '{8'h02, 8'h02}, '{8'h48, 8'h80}, '{8'hA0, 8'h40}, '{8'h04, 8'h24}}
  };

  // x feeding byte bits 1..5, per board and emitted colour (red, blue, green)
  localparam int X_ORDER [BOARDS][3][SIDE] = '{
    '{'{1, 0, 2, 3, 4}, '{1, 0, 2, 3, 4}, '{1, 0, 4, 3, 2}},
    '{'{1, 0, 2, 3, 4}, '{1, 0, 4, 3, 2}, '{1, 0, 2, 3, 4}},
    '{'{3, 4, 2, 1, 0}, '{3, 4, 2, 1, 0}, '{3, 4, 2, 1, 0}}
  };

  // store bit per emitted colour: red 0, blue 2, green 1
  localparam int STORE_BIT [3] = '{0, 2, 1};

  logic [2:0]        cube [SIDE*SIDE*SIDE];
  logic [2:0]        layer;
  logic [1:0]        board;
  lcls_pkg::result_t frame_q [$];
  int                err_count;

  function automatic int voxel_at(int x, int y, int z);
    return x + SIDE * y + SIDE * SIDE * z;
  endfunction

  task automatic apply_item(input lcls_pkg::item_t it);
    logic [7:0]        frame [FRAME_BYTES];
    logic [7:0]        acc;
    lcls_pkg::result_t beat;
    int                k;
    case (it.kind)
      lcls_pkg::KIND_WRITE: begin
        if (it.pos_x < SIDE && it.pos_y < SIDE && it.pos_z < SIDE) begin
          cube[voxel_at(it.pos_x, it.pos_y, it.pos_z)] = it.colour_bits;
        end
      end
      lcls_pkg::KIND_CLEAR: begin
        foreach (cube[i]) cube[i] = '0;
      end
      lcls_pkg::KIND_TICK: begin
        layer = (layer == 3'(SIDE - 1)) ? 3'd0 : layer + 3'd1;
        foreach (frame[i]) frame[i] = '0;
        // unknown board: all seventeen bytes stay zero
        if (board < BOARDS) begin
          frame[0] = SELECT_BYTES[board][layer][0];
          frame[1] = SELECT_BYTES[board][layer][1];
          k = 2;
          for (int c = 0; c < 3; c++) begin
            for (int y = SIDE - 1; y >= 0; y--) begin
              acc = '0;
              for (int b = 0; b < SIDE; b++) begin
                acc[b + 1] = cube[voxel_at(X_ORDER[board][c][b], y, layer)][STORE_BIT[c]];
              end
              frame[k] = acc;
              k++;
            end
          end
        end
        for (int i = 0; i < FRAME_BYTES; i++) begin
          beat.out_byte = frame[i];
          beat.last     = (i == FRAME_BYTES - 1);
          frame_q.push_back(beat);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    lcls_pkg::result_t want;
    if (rst) begin
      foreach (cube[i]) cube[i] = '0;
      layer = '0;
      board = '0;
      frame_q.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (frame_q.size() == 0) begin
          $display("%0t: result beat with none expected: got byte %h last %b",
                   $time, res.out_byte, res.last);
          err_count++;
        end else begin
          want = frame_q.pop_front();
          if (res.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h, got %h",
                     $time, want.out_byte, res.out_byte);
            err_count++;
          end
          if (res.last !== want.last) begin
            $display("%0t: last mismatch: expected %b, got %b", $time, want.last, res.last);
            err_count++;
          end
        end
      end
      if (cfg_we) board = cfg_wdata;
      if (item_valid && item_ready) apply_item(item);
    end
    errors  <= err_count;
    pending <= frame_q.size();
  end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// stimulus for the led cube scan driver: a directed opening on board 0, then
// random phases on every board setting, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 70;
  localparam logic [1:0] PHASE_BOARD [PHASES] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  lcls_pkg::item_t   item;
  logic              res_valid;
  logic              res_ready;
  lcls_pkg::result_t res;
  logic              cfg_we;
  logic [1:0]        cfg_wdata;
  int                errors;
  int                pending;
  int                cycles = 0;
  bit                calm = 1'b0;

  led_cube_layer_scan_driver_top DUT (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  lcls_scan_checker frame_check (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stall bursts between ready stretches
  initial begin
    int hold;
    hold = 0;
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!calm && res_ready && $urandom_range(0, 3) == 0) begin
        res_ready <= 1'b0;
        hold = $urandom_range(0, 7);
      end else begin
        res_ready <= 1'b1;
        hold = $urandom_range(0, 24);
      end
    end
  end

  function automatic lcls_pkg::item_t make_item(logic [1:0] kind, int x, int y, int z,
                                                int colour);
    lcls_pkg::item_t it;
    it.kind        = kind;
    it.pos_x       = 3'(x);
    it.pos_y       = 3'(y);
    it.pos_z       = 3'(z);
    it.colour_bits = 3'(colour);
    return it;
  endfunction

  // mostly in-range writes and ticks, some broken writes, clears and noise
  function automatic lcls_pkg::item_t random_item();
    lcls_pkg::item_t it;
    int              pick;
    pick = $urandom_range(0, 99);
    it = make_item(lcls_pkg::KIND_WRITE, $urandom_range(0, 4), $urandom_range(0, 4),
                   $urandom_range(0, 4), $urandom_range(0, 7));
    if (pick >= 55 && pick < 62) begin
      it = make_item(lcls_pkg::KIND_WRITE, $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 7), $urandom_range(0, 7));
      case ($urandom_range(0, 2))
        0: it.pos_x = 3'($urandom_range(5, 7));
        1: it.pos_y = 3'($urandom_range(5, 7));
        default: it.pos_z = 3'($urandom_range(5, 7));
      endcase
    end else if (pick >= 62) begin
      it = make_item(lcls_pkg::KIND_TICK, $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 7), $urandom_range(0, 7));
      if (pick >= 94) it.kind = KIND_IGNORED;
      else if (pick >= 92) it.kind = lcls_pkg::KIND_CLEAR;
    end
    return it;
  endfunction

  // valid stays high across back-to-back items; only a gap or a drain lowers it
  task automatic send_item(input lcls_pkg::item_t it);
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic idle_gap();
    item_valid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  // hold off until every beat is back, then cover a write still in flight
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_board(input logic [1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_board(2'd0);

    // empty store, first tick shows layer 1
    send_item(make_item(lcls_pkg::KIND_TICK, 0, 0, 0, 0));
    send_item(make_item(lcls_pkg::KIND_WRITE, 0, 0, 2, 1));
    send_item(make_item(lcls_pkg::KIND_WRITE, 4, 4, 2, 7));
    send_item(make_item(lcls_pkg::KIND_WRITE, 2, 3, 2, 2));
    send_item(make_item(lcls_pkg::KIND_WRITE, 1, 1, 2, 4));
    // out-of-range coordinates are dropped
    send_item(make_item(lcls_pkg::KIND_WRITE, 7, 0, 2, 7));
    send_item(make_item(lcls_pkg::KIND_WRITE, 0, 5, 2, 7));
    send_item(make_item(lcls_pkg::KIND_WRITE, 0, 0, 7, 7));
    send_item(make_item(KIND_IGNORED, 7, 7, 7, 7));
    send_item(make_item(lcls_pkg::KIND_TICK, 0, 0, 0, 0));
    send_item(make_item(lcls_pkg::KIND_WRITE, 0, 0, 0, 7));
    send_item(make_item(lcls_pkg::KIND_WRITE, 4, 4, 4, 7));
    // layers 3, 4, then wrap to 0
    send_item(make_item(lcls_pkg::KIND_TICK, 0, 0, 0, 0));
    send_item(make_item(lcls_pkg::KIND_TICK, 7, 7, 7, 7));
    send_item(make_item(lcls_pkg::KIND_TICK, 0, 0, 0, 0));
    send_item(make_item(lcls_pkg::KIND_CLEAR, 0, 0, 0, 0));
    send_item(make_item(lcls_pkg::KIND_TICK, 0, 0, 0, 0));
    send_item(make_item(lcls_pkg::KIND_WRITE, 3, 2, 2, 5));
    send_item(make_item(lcls_pkg::KIND_WRITE, 3, 2, 2, 0));
    send_item(make_item(lcls_pkg::KIND_TICK, 0, 0, 0, 0));

    for (int p = 0; p < PHASES; p++) begin
      set_board(PHASE_BOARD[p]);
      calm = (p == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (!calm && $urandom_range(0, 59) == 0) drain();
        else if (!calm && $urandom_range(0, 7) == 0) idle_gap();
        send_item(random_item());
      end
    end

    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
